>>> rtl/sise_pkg.sv
`timescale 1ns / 1ps
package sise_pkg;

  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_REMOVE = 3'd1,
    OP_SUB    = 3'd2,
    OP_ISECT  = 3'd3,
    OP_COVER  = 3'd4,
    OP_NEXT   = 3'd5,
    OP_REND   = 3'd6,
    OP_RSTART = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_END
  } state_e;

  typedef enum logic [1:0] {
    RM_SEARCH,
    RM_RUN,
    RM_STOP
  } run_mode_e;

  typedef struct packed {
    op_e         op;
    logic [47:0] range_offset;
    logic [47:0] range_size;
    logic [47:0] position;
    logic [47:0] join_gap;
  } req_t;

  typedef struct packed {
    logic [47:0] piece_offset;
    logic [47:0] piece_size;
    logic        found;
    logic [47:0] run_bound;
    logic [48:0] bytes_held;
    logic        table_full;
    logic        last;
  } res_t;

  typedef struct packed {
    logic pop;
    logic push;
  } chain_ctrl_t;

  localparam logic [47:0] Max48 = 48'hFFFF_FFFF_FFFF;
  localparam logic [48:0] Max49 = 49'h1_FFFF_FFFF_FFFF;

  function automatic logic is_range_op(op_e op);
    return (op == OP_ADD) || (op == OP_REMOVE) || (op == OP_SUB) || (op == OP_ISECT);
  endfunction

endpackage

>>> rtl/sise_cell.sv
`timescale 1ns / 1ps
module sise_cell #(
  parameter int OFFSET_BITS = 48
) (
  input  logic                      clk_i,
  input  sise_pkg::chain_ctrl_t     ctrl_i,
  input  logic                      sel_i,
  input  logic [OFFSET_BITS-1:0]    push_lo_i,
  input  logic [OFFSET_BITS:0]      push_hi_i,
  input  logic [OFFSET_BITS-1:0]    nb_lo_i,
  input  logic [OFFSET_BITS:0]      nb_hi_i,
  output logic [OFFSET_BITS-1:0]    lo_o,
  output logic [OFFSET_BITS:0]      hi_o
);
  import sise_pkg::*;

  logic [OFFSET_BITS-1:0] lo_q, lo_d;
  logic [OFFSET_BITS:0]   hi_q, hi_d;

  // push wins over shift; shift takes the neighbor toward the tail
  always_comb begin
    lo_d = lo_q;
    hi_d = hi_q;
    if (ctrl_i.push && sel_i) begin
      lo_d = push_lo_i;
      hi_d = push_hi_i;
    end else if (ctrl_i.pop) begin
      lo_d = nb_lo_i;
      hi_d = nb_hi_i;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q <= lo_d;
    hi_q <= hi_d;
  end

  assign lo_o = lo_q;
  assign hi_o = hi_q;

endmodule

>>> rtl/sise_chain.sv
`timescale 1ns / 1ps
module sise_chain #(
  parameter int MAX_ENTRIES = 16,
  parameter int OFFSET_BITS = 48,
  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
  input  logic                      clk_i,
  input  sise_pkg::chain_ctrl_t     ctrl_i,
  input  logic [AW-1:0]             idx_i,
  input  logic [OFFSET_BITS-1:0]    push_lo_i,
  input  logic [OFFSET_BITS:0]      push_hi_i,
  output logic [OFFSET_BITS-1:0]    head_lo_o,
  output logic [OFFSET_BITS:0]      head_hi_o
);
  import sise_pkg::*;

  logic [OFFSET_BITS-1:0] lo_w [MAX_ENTRIES];
  logic [OFFSET_BITS:0]   hi_w [MAX_ENTRIES];

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    logic [OFFSET_BITS-1:0] nb_lo;
    logic [OFFSET_BITS:0]   nb_hi;
    if (i == MAX_ENTRIES - 1) begin : g_tail
      assign nb_lo = lo_w[i];
      assign nb_hi = hi_w[i];
    end else begin : g_mid
      assign nb_lo = lo_w[i+1];
      assign nb_hi = hi_w[i+1];
    end
    sise_cell #(
      .OFFSET_BITS(OFFSET_BITS)
    ) u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl_i),
      .sel_i     (idx_i == AW'(i)),
      .push_lo_i (push_lo_i),
      .push_hi_i (push_hi_i),
      .nb_lo_i   (nb_lo),
      .nb_hi_i   (nb_hi),
      .lo_o      (lo_w[i]),
      .hi_o      (hi_w[i])
    );
  end

  assign head_lo_o = lo_w[0];
  assign head_hi_o = hi_w[0];

endmodule

>>> rtl/sorted_interval_set_engine_unit.sv
`timescale 1ns / 1ps
// Channel   | Ports                         | Handshake
// ----------+-------------------------------+----------------------------------
// request   | start_i, busy_o, req_i        | taken when start_i && !busy_o
// result    | res_valid_o, res_o            | one cycle per result, no stall
//
// Entries live in a chain of cells that shifts toward the head one step per
// cycle while popped; the control walks the head and writes back at the tail of the queue.
// Queries walk the entries once; subtract with a trailing gap emits it at the end.
// Add and remove take two walks (a counting walk, then a rewrite walk);
// a refused one ends after the counting walk.
// Zero-size range requests finish in the cycle they are taken.
// Results show in the cycle after they are formed; the receiver cannot stall.
// Reset empties the table at once; cell contents are not cleared.
module sorted_interval_set_engine_unit #(
  parameter int MAX_ENTRIES = 16,
  parameter int OFFSET_BITS = 48
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  sise_pkg::req_t   req_i,
  output logic             res_valid_o,
  output sise_pkg::res_t   res_o
);
  import sise_pkg::*;

  localparam int OB = OFFSET_BITS;
  localparam int VW = (OB + 2 > 50) ? OB + 2 : 50;
  localparam int IW = $clog2(MAX_ENTRIES + 1);
  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int NW = $clog2(2 * MAX_ENTRIES + 2);
  localparam logic [VW-1:0] Limit = {{(VW-1){1'b0}}, 1'b1} << OB;

  state_e       state_q, state_d;
  op_e          op_q, op_d;
  logic [VW-1:0] s_q, s_d, e_q, e_d, pos_q, pos_d, gap_q, gap_d;
  logic [VW-1:0] ns_q, ns_d, ne_q, ne_d, cur_q, cur_d, acc_q, acc_d;
  logic [VW-1:0] hoff_q, hoff_d, hsz_q, hsz_d, rb_q, rb_d, lastb_q, lastb_d;
  logic [VW-1:0] rs_q, rs_d, pend_off_q, pend_off_d, pend_sz_q, pend_sz_d;
  logic [VW-1:0] total_q, total_d;
  logic          ins_q, ins_d, sub_q, sub_d, wr_q, wr_d, hit_q, hit_d;
  logic          seen_q, seen_d, pend_v_q, pend_v_d, res_v_q, res_v_d;
  run_mode_e     rmode_q, rmode_d;
  logic [NW-1:0] cnt_q, cnt_d, n_fin;
  logic [IW-1:0] count_q, count_d, occ_q, occ_d, rd_q, rd_d;
  res_t          res_q, res_d;

  chain_ctrl_t   ctrl;
  logic [AW-1:0] push_idx;
  logic [VW-1:0] pd_lo, pd_hi;
  logic [OB-1:0] head_lo;
  logic [OB:0]   head_hi;
  logic [VW-1:0] a, b, off_in, sum_in, s_in, e_in, pos_in, gap_in;
  logic          empty_in;
  logic          prod, flush, left_cut, right_cut;
  logic [VW-1:0] prod_off, prod_sz, lo_v, hi_v, spacing;

  function automatic logic [47:0] sat48(logic [VW-1:0] v);
    logic [VW-1:0] m;
    m = {{(VW-48){1'b0}}, Max48};
    return (v > m) ? Max48 : v[47:0];
  endfunction

  function automatic res_t mk_res(logic [VW-1:0] off, logic [VW-1:0] sz, logic fnd,
                                  logic [VW-1:0] bnd, logic [VW-1:0] bytes,
                                  logic full, logic lst);
    res_t r;
    logic [VW-1:0] m49;
    m49 = {{(VW-49){1'b0}}, Max49};
    r.piece_offset = off[47:0];
    r.piece_size   = sat48(sz);
    r.found        = fnd;
    r.run_bound    = sat48(bnd);
    r.bytes_held   = (bytes > m49) ? Max49 : bytes[48:0];
    r.table_full   = full;
    r.last         = lst;
    return r;
  endfunction

  sise_chain #(
    .MAX_ENTRIES(MAX_ENTRIES),
    .OFFSET_BITS(OFFSET_BITS)
  ) u_chain (
    .clk_i     (clk_i),
    .ctrl_i    (ctrl),
    .idx_i     (push_idx),
    .push_lo_i (pd_lo[OB-1:0]),
    .push_hi_i (pd_hi[OB:0]),
    .head_lo_o (head_lo),
    .head_hi_o (head_hi)
  );

  assign a = {{(VW-OB){1'b0}}, head_lo};
  assign b = {{(VW-OB-1){1'b0}}, head_hi};

  // clamp both ends of the request range to the offset limit
  assign off_in   = {{(VW-48){1'b0}}, req_i.range_offset};
  assign sum_in   = off_in + {{(VW-48){1'b0}}, req_i.range_size};
  assign s_in     = (off_in > Limit) ? Limit : off_in;
  assign e_in     = (sum_in > Limit) ? Limit : sum_in;
  assign empty_in = (e_in <= s_in);
  assign pos_in   = {{(VW-48){1'b0}}, req_i.position};
  assign gap_in   = {{(VW-48){1'b0}}, req_i.join_gap};

  assign n_fin = cnt_q + NW'(op_q == OP_ADD && !ins_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i && !(is_range_op(req_i.op) && empty_in)) state_d = ST_WALK;
      end
      ST_WALK: begin
        if (rd_q == '0) state_d = ST_END;
      end
      ST_END: begin
        case (op_q)
          OP_ADD, OP_REMOVE: begin
            if (!wr_q) begin
              state_d = (n_fin > NW'(MAX_ENTRIES)) ? ST_IDLE : ST_WALK;
            end else if (!(op_q == OP_ADD && !ins_q)) begin
              state_d = ST_IDLE;
            end
          end
          OP_SUB: begin
            if (cur_q >= e_q) state_d = ST_IDLE;
          end
          default: state_d = ST_IDLE;
        endcase
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    op_d = op_q; s_d = s_q; e_d = e_q; pos_d = pos_q; gap_d = gap_q;
    ns_d = ns_q; ne_d = ne_q; cur_d = cur_q; acc_d = acc_q;
    hoff_d = hoff_q; hsz_d = hsz_q; rb_d = rb_q; lastb_d = lastb_q; rs_d = rs_q;
    pend_off_d = pend_off_q; pend_sz_d = pend_sz_q; total_d = total_q;
    ins_d = ins_q; sub_d = sub_q; wr_d = wr_q; hit_d = hit_q; seen_d = seen_q;
    pend_v_d = pend_v_q; rmode_d = rmode_q; cnt_d = cnt_q;
    count_d = count_q; rd_d = rd_q;
    res_d = res_q; res_v_d = 1'b0;
    ctrl = '0; pd_lo = a; pd_hi = b;
    prod = 1'b0; prod_off = '0; prod_sz = '0; flush = 1'b0;
    left_cut = (a < s_q); right_cut = (b > e_q);
    lo_v = (a > s_q) ? a : s_q;
    hi_v = (b < e_q) ? b : e_q;
    spacing = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          op_d = req_i.op; s_d = s_in; e_d = e_in; pos_d = pos_in; gap_d = gap_in;
          ns_d = s_in; ne_d = e_in; cur_d = s_in; acc_d = '0; rb_d = pos_in;
          ins_d = 1'b0; sub_d = 1'b0; wr_d = 1'b0; hit_d = 1'b0; seen_d = 1'b0;
          pend_v_d = 1'b0; rmode_d = RM_SEARCH; cnt_d = '0; rd_d = count_q;
          hoff_d = '0; hsz_d = '0;
          if (is_range_op(req_i.op) && empty_in) begin
            res_d = mk_res('0, '0, 1'b0, '0, total_q, 1'b0, 1'b1);
            res_v_d = 1'b1;
          end
        end
      end
      ST_WALK: begin
        if (rd_q != '0) begin
          // rotate the head to the tail unless the rewrite walk says otherwise
          ctrl.pop = 1'b1;
          ctrl.push = 1'b1;
          case (op_q)
            OP_ADD: begin
              if (b < s_q) begin
                cnt_d = cnt_q + NW'(1);
              end else if (a <= ne_q) begin
                ns_d = (a < ns_q) ? a : ns_q;
                ne_d = (b > ne_q) ? b : ne_q;
                if (wr_q) ctrl.push = 1'b0;
              end else if (!ins_q) begin
                ins_d = 1'b1;
                cnt_d = cnt_q + NW'(2);
                if (wr_q) begin
                  // insert the merged range ahead, hold the head
                  ctrl.pop = 1'b0;
                  pd_lo = ns_q;
                  pd_hi = ne_q;
                end
              end else begin
                cnt_d = cnt_q + NW'(1);
              end
            end
            OP_REMOVE: begin
              if (b <= s_q || a >= e_q) begin
                cnt_d = cnt_q + NW'(1);
              end else begin
                cnt_d = cnt_q + NW'(left_cut) + NW'(right_cut);
                if (wr_q) begin
                  if (left_cut && right_cut && !sub_q) begin
                    ctrl.pop = 1'b0;
                    sub_d = 1'b1;
                    pd_hi = s_q;
                  end else if (sub_q) begin
                    sub_d = 1'b0;
                    pd_lo = e_q;
                  end else if (left_cut) begin
                    pd_hi = s_q;
                  end else if (right_cut) begin
                    pd_lo = e_q;
                  end else begin
                    ctrl.push = 1'b0;
                  end
                end
              end
            end
            OP_SUB: begin
              if (b > cur_q && a < e_q) begin
                if (a > cur_q) begin
                  prod = 1'b1; prod_off = cur_q; prod_sz = a - cur_q;
                end
                cur_d = b;
              end
            end
            OP_ISECT: begin
              if (b > s_q && a < e_q) begin
                prod = 1'b1; prod_off = lo_v; prod_sz = hi_v - lo_v;
              end
            end
            OP_COVER: begin
              if (a <= pos_q && pos_q < b) begin
                hit_d = 1'b1; hoff_d = a; hsz_d = b - a;
              end
            end
            OP_NEXT: begin
              if (!hit_q && a > pos_q) begin
                hit_d = 1'b1; hoff_d = a; hsz_d = b - a;
              end
            end
            OP_REND: begin
              case (rmode_q)
                RM_SEARCH: begin
                  if (a <= pos_q) begin
                    if (pos_q < b) begin
                      rmode_d = RM_RUN; rb_d = b;
                    end
                  end else if (a - pos_q < gap_q) begin
                    rmode_d = RM_RUN; rb_d = b;
                  end else begin
                    rmode_d = RM_STOP;
                  end
                end
                RM_RUN: begin
                  spacing = (a > rb_q) ? a - rb_q : '0;
                  if (spacing >= gap_q) rmode_d = RM_STOP;
                  else rb_d = b;
                end
                default: ;
              endcase
            end
            default: begin
              if (a <= pos_q) begin
                spacing = (a > lastb_q) ? a - lastb_q : '0;
                if (!seen_q || spacing >= gap_q) rs_d = a;
                seen_d = 1'b1;
                lastb_d = b;
              end
            end
          endcase
        end
      end
      ST_END: begin
        case (op_q)
          OP_ADD, OP_REMOVE: begin
            if (!wr_q) begin
              if (n_fin > NW'(MAX_ENTRIES)) begin
                res_d = mk_res('0, '0, 1'b0, '0, total_q, 1'b1, 1'b1);
                res_v_d = 1'b1;
              end else begin
                wr_d = 1'b1; rd_d = count_q; ns_d = s_q; ne_d = e_q;
                ins_d = 1'b0; sub_d = 1'b0; acc_d = '0;
              end
            end else if (op_q == OP_ADD && !ins_q) begin
              // merged range goes last
              ctrl.push = 1'b1;
              pd_lo = ns_q;
              pd_hi = ne_q;
              ins_d = 1'b1;
            end else begin
              count_d = occ_q;
              total_d = acc_q;
              res_d = mk_res('0, '0, 1'b0, '0, acc_q, 1'b0, 1'b1);
              res_v_d = 1'b1;
            end
          end
          OP_SUB: begin
            if (cur_q < e_q) begin
              prod = 1'b1; prod_off = cur_q; prod_sz = e_q - cur_q;
              cur_d = e_q;
            end else begin
              flush = 1'b1;
            end
          end
          OP_ISECT: flush = 1'b1;
          OP_COVER, OP_NEXT: begin
            res_d = mk_res(hoff_q, hsz_q, hit_q, '0, total_q, 1'b0, 1'b1);
            res_v_d = 1'b1;
          end
          OP_REND: begin
            res_d = mk_res('0, '0, 1'b0, rb_q, total_q, 1'b0, 1'b1);
            res_v_d = 1'b1;
          end
          default: begin
            spacing = (pos_q >= lastb_q) ? pos_q - lastb_q : '0;
            res_d = mk_res('0, '0, 1'b0,
                           (!seen_q || (pos_q >= lastb_q && spacing >= gap_q)) ? pos_q : rs_q,
                           total_q, 1'b0, 1'b1);
            res_v_d = 1'b1;
          end
        endcase
      end
      default: ;
    endcase

    if (ctrl.pop) rd_d = rd_q - IW'(1);
    if (wr_q && ctrl.push) acc_d = acc_q + (pd_hi - pd_lo);

    // hold one piece back so the final one can carry last
    if (prod) begin
      if (pend_v_q) begin
        res_d = mk_res(pend_off_q, pend_sz_q, 1'b1, '0, total_q, 1'b0, 1'b0);
        res_v_d = 1'b1;
      end
      pend_v_d = 1'b1; pend_off_d = prod_off; pend_sz_d = prod_sz;
    end
    if (flush) begin
      if (pend_v_q) res_d = mk_res(pend_off_q, pend_sz_q, 1'b1, '0, total_q, 1'b0, 1'b1);
      else res_d = mk_res('0, '0, 1'b0, '0, total_q, 1'b0, 1'b1);
      res_v_d = 1'b1;
      pend_v_d = 1'b0;
    end
  end

  assign occ_d    = occ_q + IW'(ctrl.push) - IW'(ctrl.pop);
  assign push_idx = AW'(occ_q - IW'(ctrl.pop));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      count_q  <= '0;
      occ_q    <= '0;
      rd_q     <= '0;
      total_q  <= '0;
      res_v_q  <= 1'b0;
      pend_v_q <= 1'b0;
      wr_q     <= 1'b0;
      ins_q    <= 1'b0;
      sub_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      occ_q    <= occ_d;
      rd_q     <= rd_d;
      total_q  <= total_d;
      res_v_q  <= res_v_d;
      pend_v_q <= pend_v_d;
      wr_q     <= wr_d;
      ins_q    <= ins_d;
      sub_q    <= sub_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; s_q <= s_d; e_q <= e_d; pos_q <= pos_d; gap_q <= gap_d;
    ns_q <= ns_d; ne_q <= ne_d; cur_q <= cur_d; acc_q <= acc_d;
    hoff_q <= hoff_d; hsz_q <= hsz_d; rb_q <= rb_d; lastb_q <= lastb_d; rs_q <= rs_d;
    pend_off_q <= pend_off_d; pend_sz_q <= pend_sz_d;
    hit_q <= hit_d; seen_q <= seen_d; rmode_q <= rmode_d; cnt_q <= cnt_d;
    res_q <= res_d;
  end

  assign busy_o      = (state_q != ST_IDLE);
  assign res_valid_o = res_v_q;
  assign res_o       = res_q;

  a_idle_occ : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o |-> occ_q == count_q)
    else $error("chain occupancy differs from entry count while idle");

  a_occ_max : assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= IW'(MAX_ENTRIES))
    else $error("chain overfilled");

  a_mid_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.last |-> busy_o)
    else $error("non-final result after request finished");

  a_full_shape : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.table_full |-> res_o.last && !res_o.found)
    else $error("table_full on a piece result");

endmodule
